// ===== design/gwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// gwpt_pkg
// Shared types, constants and helpers for the grid wavefront path tracer.
// ----------------------------------------------------------------------------
package gwpt_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef struct packed {
        logic [7:0] d;
        logic [7:0] x;
        logic [7:0] y;
    } entry_t;

    typedef struct packed {
        logic fwd;
        logic rev;
        logic copy;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_TRACE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE = 3'd0,
        ST_REPL = 3'd1,
        ST_IGN  = 3'd2,
        ST_FULL = 3'd3,
        ST_PATH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_COPY,
        S_EMIT,
        S_FINISH
    } state_t;

    function automatic logic adjacent(input entry_t a, input entry_t b);
        logic [8:0] ay;
        logic [8:0] ax;
        logic [8:0] by;
        logic [8:0] bx;
        ay = {1'b0, a.y};
        ax = {1'b0, a.x};
        by = {1'b0, b.y};
        bx = {1'b0, b.x};
        return ((ay == by) && ((ax == bx + 9'd1) || (bx == ax + 9'd1))) ||
               ((ax == bx) && ((ay == by + 9'd1) || (by == ay + 9'd1)));
    endfunction

endpackage

// ===== design/grid_wavefront_path_tracer_unit.sv =====
// ----------------------------------------------------------------------------
// grid_wavefront_path_tracer_unit
// Lee router node list: start, add with duplicate search, advance and
// backward path trace over a ring of list cells.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// s_axis  | in  | tuser: func; tdata: node_y, node_x, node_dist
// m_axis  | out | tuser: status; tdata: path_y, path_x, path_dist; tlast: last
//
// Start and advance pass through a finish state; add makes one full ring turn.
// Trace makes a reverse turn for the walk, a copy, and a forward turn that
// emits the path; emission stalls on m_axis_tready.
// One item at a time; a result waits in the output register.
// Reset clears control state; list contents are undefined until written.
module grid_wavefront_path_tracer_unit
    import gwpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node_y, node_x, node_dist
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // path_y, path_x, path_dist
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  expand_reg, expand_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              hit_reg, hit_next;
    status_t           st_reg, st_next;
    entry_t            cur_reg, cur_next;
    entry_t            in_reg, in_next;

    logic              out_valid_reg;
    entry_t            out_data_reg;
    status_t           out_st_reg;
    logic              out_last_reg;
    logic              out_load;
    entry_t            out_data;
    status_t           out_st;
    logic              out_last;
    logic              out_free;

    chain_ctrl_t       ctrl;
    entry_t            cells [LIST_DEPTH];
    entry_t            head_mod;
    logic              ld0;
    entry_t            ld_data;
    logic              ps_we;
    entry_t            tail;
    logic [IDX_W-1:0]  walk_idx;
    logic [IDX_W-1:0]  start_idx;
    logic              accept;
    logic              last_step;
    func_t             func_in;

    assign func_in   = func_t'(s_axis_tuser);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_step = (step_reg == IDX_W'(LIST_DEPTH - 1));
    assign tail      = cells[LIST_DEPTH-1];
    assign walk_idx  = IDX_W'(LIST_DEPTH - 1) - step_reg;
    assign start_idx = ({1'b0, expand_reg} >= CNT_W'(count_reg))
                       ? IDX_W'(count_reg - CNT_W'(1)) : expand_reg;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    unique case (func_in)
                        FUNC_ADD:   state_next = S_SCAN;
                        FUNC_TRACE: state_next = (count_reg == '0) ? S_FINISH : S_WALK;
                        default:    state_next = S_FINISH;
                    endcase
                end
            S_SCAN:   if (last_step) state_next = S_FINISH;
            S_WALK:   if (last_step) state_next = S_COPY;
            S_COPY:   state_next = S_EMIT;
            S_EMIT:
                if (last_step && ((CNT_W'(step_reg) >= len_reg) || out_free))
                    state_next = S_IDLE;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        step_next   = step_reg;
        count_next  = count_reg;
        expand_next = expand_reg;
        len_next    = len_reg;
        hit_next    = hit_reg;
        st_next     = st_reg;
        cur_next    = cur_reg;
        in_next     = in_reg;
        ctrl        = '0;
        head_mod    = cells[0];
        ld0         = 1'b0;
        ld_data     = in_reg;
        ps_we       = 1'b0;
        out_load    = 1'b0;
        out_data    = '0;
        out_st      = st_reg;
        out_last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    in_next   = entry_t'(s_axis_tdata);
                    step_next = '0;
                    st_next   = ST_DONE;
                    hit_next  = 1'b0;
                    len_next  = '0;
                    unique case (func_in)
                        FUNC_START:
                        begin
                            ld0         = 1'b1;
                            ld_data     = entry_t'(s_axis_tdata);
                            ld_data.d   = '0;
                            count_next  = CNT_W'(1);
                            expand_next = '0;
                        end
                        FUNC_ADVANCE:
                            if (expand_reg != IDX_W'(LIST_DEPTH - 1))
                                expand_next = expand_reg + IDX_W'(1);
                        default: ;
                    endcase
                end
            S_SCAN:
            begin
                ctrl.fwd = 1'b1;
                if (!hit_reg && (CNT_W'(step_reg) < count_reg) &&
                    (cells[0].y == in_reg.y) && (cells[0].x == in_reg.x))
                begin
                    hit_next = 1'b1;
                    if (in_reg.d < cells[0].d)
                    begin
                        head_mod.d = in_reg.d;
                        st_next    = ST_REPL;
                    end
                    else
                        st_next = ST_IGN;
                end
                else if (!hit_reg && (CNT_W'(step_reg) == count_reg))
                begin
                    hit_next   = 1'b1;
                    head_mod   = in_reg;
                    count_next = count_reg + CNT_W'(1);
                    st_next    = ST_DONE;
                end
                if (last_step && !hit_next)
                    st_next = ST_FULL;
                step_next = step_reg + IDX_W'(1);
            end
            S_WALK:
            begin
                ctrl.rev = 1'b1;
                if (walk_idx == start_idx)
                begin
                    cur_next = tail;
                    ps_we    = 1'b1;
                    len_next = CNT_W'(1);
                end
                else if ((len_reg != '0) && (cur_reg.d != '0) &&
                         (tail.d == cur_reg.d - 8'd1) && adjacent(cur_reg, tail))
                begin
                    cur_next = tail;
                    ps_we    = 1'b1;
                    len_next = len_reg + CNT_W'(1);
                end
                step_next = step_reg + IDX_W'(1);
            end
            S_COPY:
            begin
                ctrl.copy   = 1'b1;
                count_next  = len_reg;
                expand_next = '0;
                step_next   = '0;
            end
            S_EMIT:
                if (CNT_W'(step_reg) < len_reg)
                begin
                    if (out_free)
                    begin
                        out_load  = 1'b1;
                        out_data  = cells[0];
                        out_st    = ST_PATH;
                        out_last  = (CNT_W'(step_reg) + CNT_W'(1) == len_reg);
                        ctrl.fwd  = 1'b1;
                        step_next = step_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    ctrl.fwd  = 1'b1;
                    step_next = step_reg + IDX_W'(1);
                end
            S_FINISH:
                out_load = out_free;
            default: ;
        endcase
    end

    genvar j;
    generate
        for (j = 0; j < LIST_DEPTH; j++)
        begin : g_cell
            entry_t up_in;
            entry_t dn_in;
            if (j == LIST_DEPTH - 1)
            begin : g_top
                assign up_in = head_mod;
            end
            else
            begin : g_mid
                assign up_in = cells[j+1];
            end
            if (j == 0)
            begin : g_bot
                assign dn_in = cells[LIST_DEPTH-1];
            end
            else
            begin : g_rest
                assign dn_in = cells[j-1];
            end
            gwpt_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .from_up (up_in),
                .from_dn (dn_in),
                .ld_en   ((j == 0) && ld0),
                .ld_data (ld_data),
                .ps_we   (ps_we && (len_reg == CNT_W'(j))),
                .ps_data (tail),
                .entry   (cells[j])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            expand_reg    <= '0;
            len_reg       <= '0;
            hit_reg       <= 1'b0;
            st_reg        <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            expand_reg <= expand_next;
            len_reg    <= len_next;
            hit_reg    <= hit_next;
            st_reg     <= st_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        in_reg  <= in_next;
        if (out_load)
        begin
            out_data_reg <= out_data;
            out_st_reg   <= out_st;
            out_last_reg <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_st_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== design/gwpt_cell.sv =====
// ----------------------------------------------------------------------------
// gwpt_cell
// One list slot: a stored entry that shifts either way along the ring, and
// a path slot that is loaded into the entry on copy.
// ----------------------------------------------------------------------------
module gwpt_cell
    import gwpt_pkg::*;
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  entry_t      from_up,
    input  entry_t      from_dn,
    input  logic        ld_en,
    input  entry_t      ld_data,
    input  logic        ps_we,
    input  entry_t      ps_data,
    output entry_t      entry
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t slot_reg;

    always_comb
    begin
        priority if (ld_en)
            entry_next = ld_data;
        else if (ctrl.copy)
            entry_next = slot_reg;
        else if (ctrl.fwd)
            entry_next = from_up;
        else if (ctrl.rev)
            entry_next = from_dn;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ps_we)
        begin
            slot_reg <= ps_data;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== design/gwpt_checker.sv =====
// ----------------------------------------------------------------------------
// gwpt_checker
// Port-level checks for the grid wavefront path tracer, bound to the top.
// ----------------------------------------------------------------------------
module gwpt_checker
    import gwpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed under stall");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new item taken while one is in work");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= 3'(ST_PATH)))
        else $error("status code out of range");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != 3'(ST_PATH)) |-> m_axis_tlast &&
        (m_axis_tdata == 24'd0))
        else $error("non-path result not final or carries data");

endmodule

bind grid_wavefront_path_tracer_unit gwpt_checker u_gwpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
